@@ design/bfma_pkg.sv @@
// Shared types and constants for the free-map block allocator.
package bfma_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_POS_W = 6;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned WIDX_W    = 16;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // Reciprocal of ten for the reserved-block count: floor(x/10) for x below 2**16
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

  // Register index, taken from paddr[2]
  localparam logic CFG_IDX_TOTAL = 1'b0;

  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;
  localparam logic [1:0] ACT_MARK  = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_block;
    logic             ok;
  } out_item_t;

  // Request to the shared word unit
  typedef struct packed {
    logic [WIDX_W-1:0]    word;
    logic [CNT_W-1:0]     lo;
    logic [CNT_W-1:0]     hi;
    logic [BIT_POS_W-1:0] bit_pos;
    logic                 set_free;
    logic                 touch;
  } wu_req_t;

  // Response from the shared word unit
  typedef struct packed {
    logic [WORD_BITS-1:0] range_word;
    logic                 found;
    logic [BIT_POS_W-1:0] pos;
    logic [WORD_BITS-1:0] alloc_word;
    logic [WORD_BITS-1:0] rmw_word;
  } wu_rsp_t;

endpackage

@@ design/bfma_map_ram.sv @@
// Free-map word memory: one write port, one registered read port.
module bfma_map_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [bfma_pkg::WORD_BITS-1:0]  wdata,
  input  logic [AW-1:0]                   raddr,
  output logic [bfma_pkg::WORD_BITS-1:0]  rdata
);

  logic [bfma_pkg::WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bfma_word_unit.sv @@
// Shared word unit: range masks, lowest-free search and bit update on one map word.
module bfma_word_unit (
  input  bfma_pkg::wu_req_t                req,
  input  logic [bfma_pkg::WORD_BITS-1:0]   rd_word,
  output bfma_pkg::wu_rsp_t                rsp
);

  // Bits of word w whose block number lies below x
  function automatic logic [bfma_pkg::WORD_BITS-1:0] below_mask(
    input logic [bfma_pkg::WIDX_W-1:0] w,
    input logic [bfma_pkg::CNT_W-1:0]  x
  );
    logic [bfma_pkg::WIDX_W-1:0]    xw;
    logic [bfma_pkg::BIT_POS_W-1:0] xb;
    xw = bfma_pkg::WIDX_W'(x >> bfma_pkg::BIT_POS_W);
    xb = x[bfma_pkg::BIT_POS_W-1:0];
    if (w < xw) begin
      return '1;
    end else if (w == xw) begin
      return ~({bfma_pkg::WORD_BITS{1'b1}} << xb);
    end else begin
      return '0;
    end
  endfunction

  logic [bfma_pkg::WORD_BITS-1:0] range_w;
  logic [bfma_pkg::WORD_BITS-1:0] cand;
  logic [bfma_pkg::BIT_POS_W-1:0] pos;
  logic [bfma_pkg::WORD_BITS-1:0] pos_bit;
  logic [bfma_pkg::WORD_BITS-1:0] upd_bit;

  assign range_w = below_mask(req.word, req.hi) & ~below_mask(req.word, req.lo);
  assign cand    = rd_word & range_w;

  // Lowest set bit of the candidate word
  always_comb begin
    pos = '0;
    for (int j = bfma_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pos = bfma_pkg::BIT_POS_W'(j);
      end
    end
  end

  assign pos_bit = {{(bfma_pkg::WORD_BITS-1){1'b0}}, 1'b1} << pos;
  assign upd_bit = {{(bfma_pkg::WORD_BITS-1){1'b0}}, 1'b1} << req.bit_pos;

  always_comb begin
    rsp.range_word = range_w;
    rsp.found      = |cand;
    rsp.pos        = pos;
    rsp.alloc_word = rd_word & ~pos_bit;
    if (!req.touch) begin
      rsp.rmw_word = rd_word;
    end else if (req.set_free) begin
      rsp.rmw_word = rd_word | upd_bit;
    end else begin
      rsp.rmw_word = rd_word & ~upd_bit;
    end
  end

endmodule

@@ design/block_free_map_allocator_core.sv @@
// Top level of the free-map block allocator: sequencer, config register and output stage.
// Init computes the reserved range, then writes every map word; allocate scans from word 0,
// one map word per cycle; free and mark do one read-modify-write, none when out of range.
// Throughput: one item at a time, plus any output stall; in_stall stays high from acceptance
// until the result sits in the output register, which frees the sequencer while it waits.
// Reset: synchronous, active low; then a clearing pass writes every map word as used, with
// in_stall high. The config port is live throughout.
module block_free_map_allocator_core #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bfma_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output bfma_pkg::out_item_t                 out_data,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfma_pkg::APB_AW-1:0]         paddr,
  input  logic [bfma_pkg::APB_DW-1:0]         pwdata,
  output logic [bfma_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + 63) / 64;
  localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_INIT  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_RMW   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [bfma_pkg::CNT_W-1:0]     total_r;
  logic [bfma_pkg::CNT_W-1:0]     nb_cur;
  logic [bfma_pkg::CNT_W-1:0]     nb_r, nb_nxt;
  logic [bfma_pkg::CNT_W-1:0]     lo_r, lo_nxt;
  logic [WA_W-1:0]                c_r, c_nxt;
  logic [1:0]                     act_r, act_nxt;
  logic [bfma_pkg::BIT_POS_W-1:0] bit_r, bit_nxt;
  logic                           touch_r, touch_nxt;
  bfma_pkg::out_item_t            res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  bfma_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                           in_fire;
  logic                           cfg_wr;
  logic                           out_free;
  logic [13:0]                    nb_plus9;
  logic [29:0]                    recip_prod;
  logic [bfma_pkg::CNT_W-1:0]     scan_last_blk;
  logic                           scan_last;
  logic [21:0]                    grant_num;

  logic                           ram_we;
  logic [WA_W-1:0]                ram_waddr;
  logic [bfma_pkg::WORD_BITS-1:0] ram_wdata;
  logic [WA_W-1:0]                ram_raddr;
  logic [bfma_pkg::WORD_BITS-1:0] ram_rdata;

  bfma_pkg::wu_req_t              wu_req;
  bfma_pkg::wu_rsp_t              wu_rsp;

  // ---------------------------------------------------------------------------
  // Configuration register. Only paddr[2] selects; everything above the list
  // reads as zero and drops writes.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bfma_pkg::CFG_IDX_TOTAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bfma_pkg::TOTAL_BLOCKS_RST;
    end else if (cfg_wr) begin
      total_r <= pwdata[bfma_pkg::CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == bfma_pkg::CFG_IDX_TOTAL) ?
                  bfma_pkg::APB_DW'(total_r) : '0;

  // Effective block count: saturate at the map size
  assign nb_cur = (32'(total_r) > MAX_BLOCKS) ? bfma_pkg::CNT_W'(MAX_BLOCKS) : total_r;

  // ---------------------------------------------------------------------------
  // Map memory and the shared word unit
  // ---------------------------------------------------------------------------
  bfma_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WA_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Allocation scans from block 0; init and the clearing pass keep blocks in [lo, nb)
  always_comb begin
    wu_req.word     = bfma_pkg::WIDX_W'(c_r);
    wu_req.lo       = (state_r == S_SCAN) ? '0 : lo_r;
    wu_req.hi       = nb_r;
    wu_req.bit_pos  = bit_r;
    wu_req.set_free = (act_r == bfma_pkg::ACT_FREE);
    wu_req.touch    = touch_r;
  end

  bfma_word_unit u_word_unit (
    .req     (wu_req),
    .rd_word (ram_rdata),
    .rsp     (wu_rsp)
  );

  // Reserved index blocks: ceil(nb/10), then the first free block is one above
  assign nb_plus9   = 14'(nb_r) + 14'd9;
  assign recip_prod = 30'(nb_plus9) * 30'(bfma_pkg::RECIP_10);

  // Last word that holds a block below the count (word 0 when the count is zero)
  assign scan_last_blk = (nb_r == '0) ? '0 : nb_r - 13'd1;
  assign scan_last     = (bfma_pkg::WIDX_W'(c_r) ==
                          bfma_pkg::WIDX_W'(scan_last_blk >> bfma_pkg::BIT_POS_W));

  assign grant_num = {bfma_pkg::WIDX_W'(c_r), wu_rsp.pos};

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Read address: the word of the next item at acceptance, the next word while scanning
  assign ram_raddr = (state_r == S_IDLE) ? c_nxt : c_r + WA_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    nb_nxt        = nb_r;
    lo_nxt        = lo_r;
    c_nxt         = c_r;
    act_nxt       = act_r;
    bit_nxt       = bit_r;
    touch_nxt     = touch_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = c_r;
    ram_wdata     = wu_rsp.range_word;

    case (state_r)
      S_CLEAR: begin
        // nb_r and lo_r are zero from reset, so every word goes out as all used
        ram_we = 1'b1;
        if (c_r == LAST_WORD) begin
          c_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          c_nxt = c_r + WA_W'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          // Latch the accepted beat
          nb_nxt    = nb_cur;
          act_nxt   = in_data.action;
          bit_nxt   = in_data.block_index[bfma_pkg::BIT_POS_W-1:0];
          touch_nxt = !((in_data.action == bfma_pkg::ACT_FREE) &&
                        (in_data.block_index == '0));
          c_nxt     = '0;
          case (in_data.action)
            bfma_pkg::ACT_INIT: begin
              state_nxt = S_PREP;
            end
            bfma_pkg::ACT_ALLOC: begin
              state_nxt = S_SCAN;
            end
            default: begin
              c_nxt = WA_W'(in_data.block_index >> bfma_pkg::BIT_POS_W);
              if (bfma_pkg::CNT_W'(in_data.block_index) < nb_cur) begin
                state_nxt = S_RMW;
              end else begin
                // Out of range: drop the update, report failure
                res_nxt.granted_block = '0;
                res_nxt.ok            = 1'b0;
                state_nxt             = S_DONE;
              end
            end
          endcase
        end
      end

      S_PREP: begin
        lo_nxt    = bfma_pkg::CNT_W'(recip_prod >> bfma_pkg::RECIP_SHIFT) + 13'd1;
        c_nxt     = '0;
        state_nxt = S_INIT;
      end

      S_INIT: begin
        ram_we = 1'b1;
        if (c_r == LAST_WORD) begin
          res_nxt.granted_block = '0;
          res_nxt.ok            = 1'b1;
          state_nxt             = S_DONE;
        end else begin
          c_nxt = c_r + WA_W'(1);
        end
      end

      S_SCAN: begin
        if (wu_rsp.found) begin
          ram_we                = 1'b1;
          ram_wdata             = wu_rsp.alloc_word;
          res_nxt.granted_block = grant_num[bfma_pkg::IDX_W-1:0];
          res_nxt.ok            = 1'b1;
          state_nxt             = S_DONE;
        end else if (scan_last) begin
          res_nxt.granted_block = '0;
          res_nxt.ok            = 1'b0;
          state_nxt             = S_DONE;
        end else begin
          c_nxt = c_r + WA_W'(1);
        end
      end

      S_RMW: begin
        ram_we                = 1'b1;
        ram_wdata             = wu_rsp.rmw_word;
        res_nxt.granted_block = '0;
        res_nxt.ok            = 1'b1;
        state_nxt             = S_DONE;
      end

      S_DONE: begin
        // Hold the result until the output register can take it
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      c_r         <= '0;
      nb_r        <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      c_r         <= c_nxt;
      nb_r        <= nb_nxt;
      lo_r        <= lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    bit_r      <= bit_nxt;
    touch_r    <= touch_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/bfma_checker.sv @@
// Port-level checker for the allocator top level, attached by bind.
module bfma_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input bfma_pkg::out_item_t         out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [bfma_pkg::APB_AW-1:0] paddr,
  input logic [bfma_pkg::APB_DW-1:0] pwdata,
  input logic [bfma_pkg::APB_DW-1:0] prdata
);

  // A taken beat keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while the previous one is still in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A failed result never carries a block number
  a_fail_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.granted_block == '0)
    else $error("failed result carries a block number");

  // A count write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && (paddr[2] == bfma_pkg::CFG_IDX_TOTAL)) ##1
    (paddr[2] == bfma_pkg::CFG_IDX_TOTAL) |->
    prdata[bfma_pkg::CNT_W-1:0] == $past(pwdata[bfma_pkg::CNT_W-1:0]))
    else $error("block count does not read back");

endmodule

bind block_free_map_allocator_core bfma_checker u_bfma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
